@@ rtl/core/rsx_pkg.sv @@
// Shared constants, types and helpers of the execute unit.
package rsx_pkg;

  localparam int MEM_WORDS   = 1024;
  localparam int REG_COUNT   = 32;
  localparam int MEM_AW      = $clog2(MEM_WORDS);
  localparam int RF_AW       = $clog2(REG_COUNT);
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_ADDI = 4'd2;
  localparam logic [3:0] OP_LI   = 4'd3;
  localparam logic [3:0] OP_BNE  = 4'd4;
  localparam logic [3:0] OP_BEQ  = 4'd5;
  localparam logic [3:0] OP_BLT  = 4'd6;
  localparam logic [3:0] OP_BGT  = 4'd7;
  localparam logic [3:0] OP_J    = 4'd8;
  localparam logic [3:0] OP_LW   = 4'd9;
  localparam logic [3:0] OP_SW   = 4'd10;
  localparam logic [3:0] OP_NOP  = 4'd11;

  typedef enum logic [3:0] {
    EK_ADD, EK_SUB, EK_ADDI, EK_LI,
    EK_BNE, EK_BEQ, EK_BLT, EK_BGT,
    EK_J, EK_LW, EK_SW, EK_NOP
  } exec_kind_t;

  typedef struct packed {
    exec_kind_t  kind;
    logic        writes_reg;
    logic [4:0]  dest_reg;
    logic [4:0]  src_reg_a;
    logic [4:0]  src_reg_b;
    logic [31:0] immediate;
    logic [15:0] target;
  } instr_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

  // Register index inside the implemented file.
  function automatic logic reg_ok(input logic [4:0] idx);
    reg_ok = ({1'b0, idx} < 6'(REG_COUNT));
  endfunction

endpackage

@@ rtl/core/risc_subset_execute_unit.sv @@
// Top level of the small-subset instruction execute unit.
//
// Usage:
//   Request channel (req_valid / req_stall) carries one decoded instruction
//   per beat: req_type, dest_reg, src_reg_a, src_reg_b, immediate, label_line.
//   Response channel (rsp_valid / rsp_stall) returns one beat per request:
//   next_pc, reg_write, written_reg, written_value, mem_fault, in order.
//   Throughput: one instruction per cycle while rsp_stall is low. Results of older
//   instructions are forwarded from the result and write-back registers, so
//   back-to-back dependent instructions (loads included) do not bubble.
//   Path: with an empty queue a request beat passes through the queue entry,
//   then register read/execute/memory, then the result register that drives rsp_valid.
//   Reset (rst, synchronous): program counter and register file read as zero;
//   the data memory is then swept to zero one word per cycle over all 1024
//   words, with req_stall held high until the sweep ends.
//   Receiver stall: the back end freezes while a result waits; the front keeps
//   taking beats into a two-entry queue and raises req_stall once it is full.
//   Memory addresses outside 0..1023 set mem_fault and drop the access.
module risc_subset_execute_unit import rsx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [3:0]  req_type,
  input  logic [4:0]  dest_reg,
  input  logic [4:0]  src_reg_a,
  input  logic [4:0]  src_reg_b,
  input  logic [31:0] immediate,
  input  logic [15:0] label_line,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [15:0] next_pc,
  output logic        reg_write,
  output logic [4:0]  written_reg,
  output logic [31:0] written_value,
  output logic        mem_fault
);

  instr_t     push_instr;
  instr_t     head;
  logic       push;
  q_stat_t    q_stat;
  back_stat_t b_stat;

  // Classify the incoming beat and hand it to the queue.
  rsx_front u_front (
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .dest_reg  (dest_reg),
    .src_reg_a (src_reg_a),
    .src_reg_b (src_reg_b),
    .immediate (immediate),
    .label_line(label_line),
    .q_stat    (q_stat),
    .b_stat    (b_stat),
    .push      (push),
    .instr     (push_instr)
  );

  // Decouples request acceptance from a frozen back end.
  rsx_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_instr),
    .pop      (b_stat.pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // Register read, execute, memory and result register.
  rsx_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_stat       (q_stat),
    .b_stat       (b_stat),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .next_pc      (next_pc),
    .reg_write    (reg_write),
    .written_reg  (written_reg),
    .written_value(written_value),
    .mem_fault    (mem_fault)
  );

  // No request is taken while the data memory sweep runs.
  a_no_req_while_clearing: assert property (@(posedge clk) disable iff (rst)
    b_stat.clearing |-> req_stall)
    else $error("request accepted during memory clear");

  // A faulting access never writes a register.
  a_fault_no_write: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && mem_fault) |-> !reg_write)
    else $error("faulting access wrote a register");

  // Queue pops only when it holds an entry.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    b_stat.pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // A response beat with no write reports zero index and value.
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !reg_write) |-> ((written_reg == 5'd0) && (written_value == 32'd0)))
    else $error("write fields not zero without a write");

endmodule

@@ rtl/core/rsx_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rsx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/rsx_front.sv @@
// Front end: request handshake and instruction classification.
module rsx_front import rsx_pkg::*; (
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [3:0]  req_type,
  input  logic [4:0]  dest_reg,
  input  logic [4:0]  src_reg_a,
  input  logic [4:0]  src_reg_b,
  input  logic [31:0] immediate,
  input  logic [15:0] label_line,
  input  q_stat_t     q_stat,
  input  back_stat_t  b_stat,
  output logic        push,
  output instr_t      instr
);

  exec_kind_t kind;

  always_comb begin
    case (req_type)
      OP_ADD:  kind = EK_ADD;
      OP_SUB:  kind = EK_SUB;
      OP_ADDI: kind = EK_ADDI;
      OP_LI:   kind = EK_LI;
      OP_BNE:  kind = EK_BNE;
      OP_BEQ:  kind = EK_BEQ;
      OP_BLT:  kind = EK_BLT;
      OP_BGT:  kind = EK_BGT;
      OP_J:    kind = EK_J;
      OP_LW:   kind = EK_LW;
      OP_SW:   kind = EK_SW;
      OP_NOP:  kind = EK_NOP;
      default: kind = EK_NOP;  // undefined codes act as nop
    endcase
  end

  always_comb begin
    instr.kind       = kind;
    instr.writes_reg = ((kind == EK_ADD) || (kind == EK_SUB) || (kind == EK_ADDI) ||
                        (kind == EK_LI) || (kind == EK_LW)) && reg_ok(dest_reg);
    instr.dest_reg   = dest_reg;
    instr.src_reg_a  = src_reg_a;
    instr.src_reg_b  = src_reg_b;
    instr.immediate  = immediate;
    instr.target     = label_line + 16'd1;
  end

  assign req_stall = q_stat.full || b_stat.clearing;
  assign push      = req_valid && !req_stall;

endmodule

@@ rtl/core/rsx_queue.sv @@
// Short instruction queue between front and back end.
module rsx_queue import rsx_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  instr_t  push_data,
  input  logic    pop,
  output instr_t  head,
  output q_stat_t q_stat
);

  instr_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;

  assign head         = entries[rd_ptr];
  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/rsx_back.sv @@
// Back end: register read, execute and memory, write back and result register.
module rsx_back import rsx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  instr_t      head,
  input  q_stat_t     q_stat,
  output back_stat_t  b_stat,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [15:0] next_pc,
  output logic        reg_write,
  output logic [4:0]  written_reg,
  output logic [31:0] written_value,
  output logic        mem_fault
);

  // clearing pass over the data memory
  logic              clearing;
  logic [MEM_AW-1:0] clr_idx;

  logic adv;
  logic pop;

  // register file: three read copies, valid bits give the zero reset
  logic [REG_COUNT-1:0] rf_vld;
  logic                 vld_a, vld_b, vld_d;
  logic [31:0]          rf_a, rf_b, rf_d;
  logic                 rf_we;

  // execute stage
  logic        e2_valid;
  instr_t      e2_i;
  logic [15:0] pc;
  logic [31:0] va, vb, vd;
  logic [31:0] alu_val;
  logic [31:0] addr32;
  logic        fault;
  logic        taken;
  logic [15:0] pc_next;
  logic        e2_wr;

  // result stage
  logic        e3_valid;
  logic [15:0] e3_next;
  logic        e3_wr;
  logic [4:0]  e3_rd;
  logic [31:0] e3_alu;
  logic        e3_load;
  logic        e3_fault;
  logic [31:0] e3_wval;

  // last committed write, for reads issued in the same cycle
  logic        wb_valid;
  logic [4:0]  wb_rd;
  logic [31:0] wb_val;

  // data memory
  logic              dm_we;
  logic [MEM_AW-1:0] dm_waddr;
  logic [31:0]       dm_wdata;
  logic [31:0]       dm_rdata;

  assign adv = !(e3_valid && rsp_stall);
  assign pop = adv && !q_stat.empty && !clearing;
  assign b_stat.clearing = clearing;
  assign b_stat.pop      = pop;

  assign e3_wval = e3_load ? dm_rdata : e3_alu;
  assign rf_we   = adv && e3_valid && e3_wr;

  function automatic logic [31:0] fwd(input logic [4:0] idx, input logic [31:0] rdat,
                                      input logic rvld);
    if (!reg_ok(idx)) begin
      fwd = '0;
    end else if (e3_valid && e3_wr && (e3_rd == idx)) begin
      fwd = e3_wval;
    end else if (wb_valid && (wb_rd == idx)) begin
      fwd = wb_val;
    end else if (rvld) begin
      fwd = rdat;
    end else begin
      fwd = '0;
    end
  endfunction

  rsx_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(e3_rd[RF_AW-1:0]), .wdata(e3_wval),
    .re(adv), .raddr(head.src_reg_a[RF_AW-1:0]), .rdata(rf_a)
  );
  rsx_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(e3_rd[RF_AW-1:0]), .wdata(e3_wval),
    .re(adv), .raddr(head.src_reg_b[RF_AW-1:0]), .rdata(rf_b)
  );
  rsx_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_d (
    .clk(clk), .we(rf_we), .waddr(e3_rd[RF_AW-1:0]), .wdata(e3_wval),
    .re(adv), .raddr(head.dest_reg[RF_AW-1:0]), .rdata(rf_d)
  );

  always_comb begin
    va     = fwd(e2_i.src_reg_a, rf_a, vld_a);
    vb     = fwd(e2_i.src_reg_b, rf_b, vld_b);
    vd     = fwd(e2_i.dest_reg, rf_d, vld_d);
    addr32 = va + e2_i.immediate;
    fault  = addr32[31] || (addr32 >= 32'(MEM_WORDS));
    case (e2_i.kind)
      EK_ADD:  alu_val = va + vb;
      EK_SUB:  alu_val = va - vb;
      EK_ADDI: alu_val = addr32;
      EK_LI:   alu_val = e2_i.immediate;
      default: alu_val = '0;
    endcase
    case (e2_i.kind)
      EK_BNE:  taken = (va != vb);
      EK_BEQ:  taken = (va == vb);
      EK_BLT:  taken = ($signed(va) < $signed(vb));
      EK_BGT:  taken = ($signed(va) > $signed(vb));
      EK_J:    taken = 1'b1;
      default: taken = 1'b0;
    endcase
    pc_next = taken ? e2_i.target : pc + 16'd1;
    e2_wr   = e2_i.writes_reg && !((e2_i.kind == EK_LW) && fault);
  end

  always_comb begin
    if (clearing) begin
      dm_we    = 1'b1;
      dm_waddr = clr_idx;
      dm_wdata = '0;
    end else begin
      dm_we    = adv && e2_valid && (e2_i.kind == EK_SW) && !fault;
      dm_waddr = addr32[MEM_AW-1:0];
      dm_wdata = vd;
    end
  end

  rsx_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .re(adv), .raddr(addr32[MEM_AW-1:0]), .rdata(dm_rdata)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      vld_a  <= rf_vld[head.src_reg_a[RF_AW-1:0]];
      vld_b  <= rf_vld[head.src_reg_b[RF_AW-1:0]];
      vld_d  <= rf_vld[head.dest_reg[RF_AW-1:0]];
      e2_i   <= head;
      e3_next  <= pc_next;
      e3_wr    <= e2_wr;
      e3_rd    <= e2_i.dest_reg;
      e3_alu   <= alu_val;
      e3_load  <= (e2_i.kind == EK_LW);
      e3_fault <= ((e2_i.kind == EK_LW) || (e2_i.kind == EK_SW)) && fault;
      wb_rd    <= e3_rd;
      wb_val   <= e3_wval;
    end
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
      rf_vld   <= '0;
      pc       <= '0;
      e2_valid <= 1'b0;
      e3_valid <= 1'b0;
      wb_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == MEM_AW'(MEM_WORDS-1)) begin
          clearing <= 1'b0;
        end
      end
      if (rf_we) begin
        rf_vld[e3_rd[RF_AW-1:0]] <= 1'b1;
      end
      if (adv) begin
        e2_valid <= pop;
        e3_valid <= e2_valid;
        wb_valid <= rf_we;
        if (e2_valid) begin
          pc <= pc_next;
        end
      end
    end
  end

  assign rsp_valid     = e3_valid;
  assign next_pc       = e3_next;
  assign reg_write     = e3_wr;
  assign written_reg   = e3_wr ? e3_rd : 5'd0;
  assign written_value = e3_wr ? e3_wval : 32'd0;
  assign mem_fault     = e3_fault;

endmodule
